>>> rtl/dsrv_pkg.sv
// ----------------------------------------------------------------------------
// dsrv_pkg: shared types and constants for the dual-slot record validator
// Holds the item structs, controller command and status structs, the
// controller state encoding, record layout constants and the CRC byte step.
// ----------------------------------------------------------------------------
package dsrv_pkg;

	localparam logic [31:0] REC_MAGIC     = 32'h4643_4247;
	localparam logic [31:0] CRC_POLY      = 32'hedb8_8320;
	localparam logic [31:0] CRC_PRESET    = 32'hffff_ffff;
	localparam logic [31:0] VERSION_OLD   = 32'd1;
	localparam logic [31:0] VERSION_NEW   = 32'd2;
	localparam logic [31:0] FRAMESKIP_MAX = 32'd2;
	localparam logic [31:0] AUDIO_MAX_OLD = 32'd1;
	localparam logic [31:0] AUDIO_MAX_NEW = 32'd4;
	localparam logic [31:0] SWAP_MAX      = 32'd1;

	localparam logic [2:0] AUDIO_LEVEL_MAX  = 3'd4;
	localparam logic [1:0] FRAMESKIP_DEFAULT = 2'd1;

	// Word positions inside a record.
	localparam logic [2:0] W_MAGIC     = 3'd0;
	localparam logic [2:0] W_VERSION   = 3'd1;
	localparam logic [2:0] W_GEN       = 3'd2;
	localparam logic [2:0] W_FRAMESKIP = 3'd3;
	localparam logic [2:0] W_AUDIO     = 3'd4;
	localparam logic [2:0] W_SWAP      = 3'd5;
	localparam logic [2:0] W_CRC       = 3'd6;
	localparam logic [2:0] W_FULL      = 3'd7;

	// Selection codes.
	localparam logic [1:0] CHOSEN_NONE  = 2'd0;
	localparam logic [1:0] CHOSEN_SLOT0 = 2'd1;
	localparam logic [1:0] CHOSEN_SLOT1 = 2'd2;

	// Index of the last byte step after the one done in the transfer cycle.
	localparam logic [1:0] CRC_LAST_STEP = 2'd2;

	typedef struct packed {
		logic [31:0] record_word;
		logic        slot_index;
		logic        end_of_record;
		logic        read_ok;
	} rec_item_t;

	typedef struct packed {
		logic        reported_slot;
		logic        slot_valid;
		logic        decision_ready;
		logic [1:0]  chosen_slot;
		logic [1:0]  frameskip_out;
		logic [2:0]  audio_out;
		logic        swap_out;
		logic [31:0] generation_out;
	} res_item_t;

	typedef struct packed {
		logic absorb;
		logic crc_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic crc_needed;
		logic out_free;
	} ctrl_sts_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CRC  = 3'b010,
		S_FIN  = 3'b100
	} ctrl_state_t;

	// Eight bit steps of the reflected CRC-32, i.e. one byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] c);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

>>> rtl/dsrv_ctrl.sv
// ----------------------------------------------------------------------------
// dsrv_ctrl: sequencing controller
// Takes record words, runs the remaining CRC byte steps and waits for room
// in the result register before finishing a record.
// ----------------------------------------------------------------------------
module dsrv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	input  logic               end_of_record,
	input  dsrv_pkg::ctrl_sts_t sts,
	output logic               rec_ready,
	output dsrv_pkg::ctrl_cmd_t cmd
);

	dsrv_pkg::ctrl_state_t state_q, state_d;
	logic [1:0] step_q, step_d;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		rec_ready    = 1'b0;
		cmd          = '0;
		unique case (state_q)
			dsrv_pkg::S_IDLE: begin
				rec_ready  = 1'b1;
				cmd.absorb = rec_valid;
				if (rec_valid) begin
					// A record end skips the remaining CRC byte steps: the record state is cleared anyway.
					if (end_of_record) begin
						state_d = dsrv_pkg::S_FIN;
					end else if (sts.crc_needed) begin
						state_d = dsrv_pkg::S_CRC;
						step_d  = '0;
					end
				end
			end
			dsrv_pkg::S_CRC: begin
				cmd.crc_step = 1'b1;
				step_d       = step_q + 2'd1;
				if (step_q == dsrv_pkg::CRC_LAST_STEP) begin
					state_d = dsrv_pkg::S_IDLE;
				end
			end
			dsrv_pkg::S_FIN: begin
				cmd.finish = sts.out_free;
				if (sts.out_free) begin
					state_d = dsrv_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dsrv_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsrv_pkg::S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

>>> rtl/dsrv_datapath.sv
// ----------------------------------------------------------------------------
// dsrv_datapath: record checks, CRC register, slot selection, result register
// Field checks and the first CRC byte happen in the transfer cycle; the
// selection and the result load happen on the finish command.
// ----------------------------------------------------------------------------
module dsrv_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dsrv_pkg::rec_item_t  rec_data,
	input  dsrv_pkg::ctrl_cmd_t  cmd,
	output dsrv_pkg::ctrl_sts_t  sts,
	input  logic                res_ready,
	output logic                res_valid,
	output dsrv_pkg::res_item_t  res_data
);

	logic [2:0]  wc_q;
	logic [31:0] crc_q;
	logic        fields_ok_q;
	logic        legacy_q;
	logic [31:0] gen_q;
	logic [1:0]  fs_q;
	logic [2:0]  au_q;
	logic        sw_q;
	logic        first_valid_q;
	logic [31:0] first_gen_q;
	logic [1:0]  first_fs_q;
	logic [2:0]  first_au_q;
	logic        first_sw_q;
	logic        last_ok_q;
	logic        last_slot_q;
	logic        res_valid_q;
	dsrv_pkg::res_item_t res_q;

	logic [31:0] w;
	logic        word_bad;
	logic [31:0] audio_limit;
	logic        rec_valid_now;
	logic [31:0] gen_diff;
	logic        newer;
	dsrv_pkg::res_item_t res_d;

	assign w              = rec_data.record_word;
	assign sts.crc_needed = rec_data.read_ok && (wc_q < dsrv_pkg::W_CRC);
	assign sts.out_free   = !res_valid_q || res_ready;
	assign audio_limit    = legacy_q ? dsrv_pkg::AUDIO_MAX_OLD : dsrv_pkg::AUDIO_MAX_NEW;

	always_comb begin
		word_bad = 1'b0;
		unique case (wc_q)
			dsrv_pkg::W_MAGIC:     word_bad = (w != dsrv_pkg::REC_MAGIC);
			dsrv_pkg::W_VERSION:   word_bad = (w != dsrv_pkg::VERSION_OLD) &&
			                                  (w != dsrv_pkg::VERSION_NEW);
			dsrv_pkg::W_GEN:       word_bad = 1'b0;
			dsrv_pkg::W_FRAMESKIP: word_bad = (w > dsrv_pkg::FRAMESKIP_MAX);
			dsrv_pkg::W_AUDIO:     word_bad = (w > audio_limit);
			dsrv_pkg::W_SWAP:      word_bad = (w > dsrv_pkg::SWAP_MAX);
			dsrv_pkg::W_CRC:       word_bad = (w != ~crc_q);
			default:               word_bad = 1'b1;
		endcase
	end

	// Selection at a record end.
	assign rec_valid_now = last_ok_q && fields_ok_q && (wc_q == dsrv_pkg::W_FULL);
	assign gen_diff      = gen_q - first_gen_q;
	assign newer         = (gen_diff != '0) && !gen_diff[31];

	always_comb begin
		res_d               = '0;
		res_d.reported_slot = last_slot_q;
		res_d.slot_valid    = rec_valid_now;
		res_d.decision_ready = last_slot_q;
		if (last_slot_q) begin
			priority if (rec_valid_now && (!first_valid_q || newer)) begin
				res_d.chosen_slot    = dsrv_pkg::CHOSEN_SLOT1;
				res_d.frameskip_out  = fs_q;
				res_d.audio_out      = au_q;
				res_d.swap_out       = sw_q;
				res_d.generation_out = gen_q;
			end else if (first_valid_q) begin
				res_d.chosen_slot    = dsrv_pkg::CHOSEN_SLOT0;
				res_d.frameskip_out  = first_fs_q;
				res_d.audio_out      = first_au_q;
				res_d.swap_out       = first_sw_q;
				res_d.generation_out = first_gen_q;
			end else begin
				res_d.chosen_slot    = dsrv_pkg::CHOSEN_NONE;
				res_d.frameskip_out  = dsrv_pkg::FRAMESKIP_DEFAULT;
				res_d.audio_out      = dsrv_pkg::AUDIO_LEVEL_MAX;
				res_d.swap_out       = 1'b0;
				res_d.generation_out = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q          <= '0;
			crc_q         <= dsrv_pkg::CRC_PRESET;
			fields_ok_q   <= 1'b1;
			legacy_q      <= 1'b0;
			gen_q         <= '0;
			fs_q          <= '0;
			au_q          <= '0;
			sw_q          <= 1'b0;
			first_valid_q <= 1'b0;
			first_gen_q   <= '0;
			first_fs_q    <= '0;
			first_au_q    <= '0;
			first_sw_q    <= 1'b0;
			last_ok_q     <= 1'b0;
			last_slot_q   <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cmd.absorb) begin
				last_ok_q   <= rec_data.read_ok;
				last_slot_q <= rec_data.slot_index;
				if (rec_data.read_ok) begin
					if (word_bad) begin
						fields_ok_q <= 1'b0;
					end
					unique case (wc_q)
						dsrv_pkg::W_VERSION:   legacy_q <= (w == dsrv_pkg::VERSION_OLD);
						dsrv_pkg::W_GEN:       gen_q    <= w;
						dsrv_pkg::W_FRAMESKIP: fs_q     <= w[1:0];
						dsrv_pkg::W_AUDIO: begin
							// Legacy records store an on/off flag that maps to full level.
							if (legacy_q) begin
								au_q <= (w != '0) ? dsrv_pkg::AUDIO_LEVEL_MAX : 3'd0;
							end else begin
								au_q <= w[2:0];
							end
						end
						dsrv_pkg::W_SWAP:      sw_q     <= w[0];
						default: begin
						end
					endcase
					if (wc_q < dsrv_pkg::W_CRC) begin
						crc_q <= dsrv_pkg::crc_byte(crc_q ^ w);
					end
					if (wc_q != dsrv_pkg::W_FULL) begin
						wc_q <= wc_q + 3'd1;
					end
				end
			end else if (cmd.crc_step) begin
				crc_q <= dsrv_pkg::crc_byte(crc_q);
			end else if (cmd.finish) begin
				if (last_slot_q) begin
					first_valid_q <= 1'b0;
				end else begin
					first_valid_q <= rec_valid_now;
					first_gen_q   <= gen_q;
					first_fs_q    <= fs_q;
					first_au_q    <= au_q;
					first_sw_q    <= sw_q;
				end
				wc_q        <= '0;
				crc_q       <= dsrv_pkg::CRC_PRESET;
				fields_ok_q <= 1'b1;
				legacy_q    <= 1'b0;
				gen_q       <= '0;
				fs_q        <= '0;
				au_q        <= '0;
				sw_q        <= 1'b0;
			end

			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> rtl/dual_slot_record_validator_unit.sv
// ----------------------------------------------------------------------------
// dual_slot_record_validator_unit: A/B settings record check and selection
// Checks two seven-word records with a reflected CRC-32 and field limits,
// reports each record end and picks the newer valid slot after slot 1.
//
//   Port group   Dir  Handshake              Payload
//   rec_*        in   rec_valid/rec_ready    dsrv_pkg::rec_item_t (one word)
//   res_*        out  res_valid/res_ready    dsrv_pkg::res_item_t (per end)
//
// A word that feeds the CRC and does not end its record is followed by three
// byte steps of the 8-bit-per-cycle CRC logic after its transfer cycle;
// other words need no CRC steps. A record end is transferred and then
// selected into the result register; the selection waits while the result
// register still holds an untaken result.
// Reset clears all record and slot state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module dual_slot_record_validator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_ready,
	input  dsrv_pkg::rec_item_t  rec_data,
	output logic                res_valid,
	input  logic                res_ready,
	output dsrv_pkg::res_item_t  res_data
);

	dsrv_pkg::ctrl_cmd_t cmd;
	dsrv_pkg::ctrl_sts_t sts;

	dsrv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.end_of_record(rec_data.end_of_record),
		.sts          (sts),
		.rec_ready    (rec_ready),
		.cmd          (cmd)
	);

	dsrv_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_data (rec_data),
		.cmd      (cmd),
		.sts      (sts),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res_data (res_data)
	);

	// The selection code never takes its unused value.
	a_chosen_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_data.chosen_slot == dsrv_pkg::CHOSEN_NONE) ||
		               (res_data.chosen_slot == dsrv_pkg::CHOSEN_SLOT0) ||
		               (res_data.chosen_slot == dsrv_pkg::CHOSEN_SLOT1)))
		else $error("chosen_slot holds an unused code");

	// A slot 0 result carries no selection.
	a_slot0_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.decision_ready) |->
		(res_data.chosen_slot == dsrv_pkg::CHOSEN_NONE) && (res_data.generation_out == '0))
		else $error("slot 0 result carries selection fields");

	// No valid slot gives the defaults.
	a_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.decision_ready &&
		 (res_data.chosen_slot == dsrv_pkg::CHOSEN_NONE)) |->
		(res_data.frameskip_out == dsrv_pkg::FRAMESKIP_DEFAULT) &&
		(res_data.audio_out == dsrv_pkg::AUDIO_LEVEL_MAX) && !res_data.swap_out)
		else $error("defaults missing when no slot is chosen");

	// A record end always stalls the input for the finish state before the next transfer.
	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_ready && rec_data.end_of_record) |=> !rec_ready)
		else $error("record end did not stall the input");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: settings record validator, slot 0 / slot 1 check and selection
// Drives seven-word settings records through the record channel with random
// idle gaps, tracks CRC-32, field limits and the slot choice alongside the
// block, and compares every report transfer field by field in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PAIR_ITEM_TARGET = 1150;
	localparam int NOISE_ITEMS      = 150;
	localparam int DRAIN_CYCLES     = 30;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                rec_valid = 1'b0;
	logic                rec_ready;
	dsrv_pkg::rec_item_t rec_data  = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	dsrv_pkg::res_item_t res_data;

	dual_slot_record_validator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec_ready (rec_ready),
		.rec_data  (rec_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #10 clk = ~clk;

	// Tracked record state and the kept slot 0 outcome.
	logic [2:0]  cnt_words;
	logic [31:0] crc_acc;
	logic        rec_good;
	logic        rec_legacy;
	logic [31:0] rec_gen;
	logic [1:0]  rec_fs;
	logic [2:0]  rec_audio;
	logic        rec_swap;
	logic        kept_valid;
	logic [31:0] kept_gen;
	logic [1:0]  kept_fs;
	logic [2:0]  kept_audio;
	logic        kept_swap;

	dsrv_pkg::res_item_t pending_reports[$];

	// Record under construction by the stimulus tasks.
	logic [31:0] draft [0:11];
	int          draft_len;

	int error_count     = 0;
	int items_sent      = 0;
	int ends_sent       = 0;
	int reports_checked = 0;
	int decisions_seen  = 0;
	int send_calm       = 0;
	int recv_calm       = 0;
	int recv_stall      = 0;

	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [31:0] w);
		logic [31:0] r;
		r = c ^ w;
		for (int i = 0; i < 32; i++) begin
			r = r[0] ? ((r >> 1) ^ dsrv_pkg::CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch with none.
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	task automatic clear_record();
		cnt_words  = '0;
		crc_acc    = dsrv_pkg::CRC_PRESET;
		rec_good   = 1'b1;
		rec_legacy = 1'b0;
		rec_gen    = '0;
		rec_fs     = '0;
		rec_audio  = '0;
		rec_swap   = 1'b0;
	endtask

	task automatic track_record_word(input dsrv_pkg::rec_item_t it);
		dsrv_pkg::res_item_t r;
		logic [31:0]         w;
		logic [31:0]         d;
		logic                good;
		logic                newer;
		w = it.record_word;
		if (it.read_ok) begin
			case (cnt_words)
				dsrv_pkg::W_MAGIC: begin
					if (w != dsrv_pkg::REC_MAGIC)
						rec_good = 1'b0;
				end
				dsrv_pkg::W_VERSION: begin
					if (w != dsrv_pkg::VERSION_OLD && w != dsrv_pkg::VERSION_NEW)
						rec_good = 1'b0;
					rec_legacy = (w == dsrv_pkg::VERSION_OLD);
				end
				dsrv_pkg::W_GEN: rec_gen = w;
				dsrv_pkg::W_FRAMESKIP: begin
					if (w > dsrv_pkg::FRAMESKIP_MAX)
						rec_good = 1'b0;
					rec_fs = w[1:0];
				end
				dsrv_pkg::W_AUDIO: begin
					if (w > (rec_legacy ? dsrv_pkg::AUDIO_MAX_OLD : dsrv_pkg::AUDIO_MAX_NEW))
						rec_good = 1'b0;
					if (rec_legacy)
						rec_audio = (w != 0) ? dsrv_pkg::AUDIO_LEVEL_MAX : 3'd0;
					else
						rec_audio = w[2:0];
				end
				dsrv_pkg::W_SWAP: begin
					if (w > dsrv_pkg::SWAP_MAX)
						rec_good = 1'b0;
					rec_swap = w[0];
				end
				dsrv_pkg::W_CRC: begin
					if (w != ~crc_acc)
						rec_good = 1'b0;
				end
				default: rec_good = 1'b0;
			endcase
			if (cnt_words < dsrv_pkg::W_CRC)
				crc_acc = crc32_step(crc_acc, w);
			if (cnt_words < dsrv_pkg::W_FULL)
				cnt_words++;
		end
		if (it.end_of_record) begin
			good = it.read_ok && rec_good && (cnt_words == dsrv_pkg::W_FULL);
			r = '0;
			r.reported_slot  = it.slot_index;
			r.slot_valid     = good;
			r.decision_ready = it.slot_index;
			if (!it.slot_index) begin
				kept_valid = good;
				kept_gen   = rec_gen;
				kept_fs    = rec_fs;
				kept_audio = rec_audio;
				kept_swap  = rec_swap;
			end else begin
				// Slot 1 wins on a signed generation difference that is positive.
				d = rec_gen - kept_gen;
				newer = (d != 0) && !d[31];
				if (good && (!kept_valid || newer)) begin
					r.chosen_slot    = dsrv_pkg::CHOSEN_SLOT1;
					r.frameskip_out  = rec_fs;
					r.audio_out      = rec_audio;
					r.swap_out       = rec_swap;
					r.generation_out = rec_gen;
				end else if (kept_valid) begin
					r.chosen_slot    = dsrv_pkg::CHOSEN_SLOT0;
					r.frameskip_out  = kept_fs;
					r.audio_out      = kept_audio;
					r.swap_out       = kept_swap;
					r.generation_out = kept_gen;
				end else begin
					r.chosen_slot    = dsrv_pkg::CHOSEN_NONE;
					r.frameskip_out  = dsrv_pkg::FRAMESKIP_DEFAULT;
					r.audio_out      = dsrv_pkg::AUDIO_LEVEL_MAX;
					r.swap_out       = 1'b0;
					r.generation_out = '0;
				end
				kept_valid = 1'b0;
			end
			pending_reports.push_back(r);
			clear_record();
		end
	endtask

	// The valid stays high after a transfer so that a zero gap needs no second
	// assignment in the same step; a later gap or the end of the stimulus lowers it.
	task automatic send_item(input logic [31:0] w, input logic slot, input logic last,
			input logic ok);
		dsrv_pkg::rec_item_t it;
		int                  n;
		it.record_word   = w;
		it.slot_index    = slot;
		it.end_of_record = last;
		it.read_ok       = ok;
		n = idle_len(send_calm);
		if (n > 0) begin
			rec_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rec_data  <= it;
		rec_valid <= 1'b1;
		do @(posedge clk); while (!rec_ready);
		track_record_word(it);
		if (ok)
			items_sent++;
		if (last)
			ends_sent++;
	endtask

	task automatic seal_draft();
		logic [31:0] c;
		c = dsrv_pkg::CRC_PRESET;
		for (int i = 0; i < 6; i++) begin
			c = crc32_step(c, draft[i]);
		end
		draft[6]  = ~c;
		draft_len = 7;
	endtask

	task automatic draft_record(input logic [31:0] version, input logic [31:0] gen,
			input logic [31:0] fs, input logic [31:0] au, input logic [31:0] sw);
		draft[0] = dsrv_pkg::REC_MAGIC;
		draft[1] = version;
		draft[2] = gen;
		draft[3] = fs;
		draft[4] = au;
		draft[5] = sw;
		seal_draft();
	endtask

	// A word with the source failing is slipped in before position noise_pos.
	task automatic emit_draft(input logic slot, input int noise_pos, input logic last_ok);
		for (int i = 0; i < draft_len; i++) begin
			if (i == noise_pos)
				send_item($urandom, slot, 1'b0, 1'b0);
			send_item(draft[i], slot, i == draft_len - 1,
				(i == draft_len - 1) ? last_ok : 1'b1);
		end
	endtask

	task automatic random_record(input logic slot, input logic [31:0] gen);
		logic [31:0] version;
		logic        legacy;
		int          noise_pos;
		logic        last_ok;
		int          extra;
		legacy  = ($urandom_range(0, 3) == 0);
		version = legacy ? dsrv_pkg::VERSION_OLD : dsrv_pkg::VERSION_NEW;
		draft_record(version, gen, $urandom_range(0, 2),
			legacy ? $urandom_range(0, 1) : $urandom_range(0, 4), $urandom_range(0, 1));
		noise_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : -1;
		last_ok   = 1'b1;
		case ($urandom_range(0, 19))
			0: begin
				draft[0] ^= 32'd1 << $urandom_range(0, 31);
				seal_draft();
			end
			1: begin
				case ($urandom_range(0, 2))
					0: draft[1] = 32'd0;
					1: draft[1] = 32'd3;
					default: draft[1] = $urandom;
				endcase
				seal_draft();
			end
			2: begin
				draft[3] = $urandom_range(0, 1) ? 32'd3 : $urandom;
				seal_draft();
			end
			3: begin
				if ($urandom_range(0, 3) == 0)
					draft[4] = $urandom;
				else
					draft[4] = legacy ? $urandom_range(2, 7) : $urandom_range(5, 7);
				seal_draft();
			end
			4: begin
				draft[5] = $urandom_range(0, 1) ? $urandom_range(2, 3) : $urandom;
				seal_draft();
			end
			5: draft[6] ^= 32'd1 << $urandom_range(0, 31);
			6: draft_len = $urandom_range(1, 6);
			7: begin
				extra = $urandom_range(1, 4);
				for (int k = 7; k < 7 + extra; k++) begin
					draft[k] = $urandom;
				end
				draft_len = 7 + extra;
			end
			8: last_ok = 1'b0;
			default: ;
		endcase
		emit_draft(slot, noise_pos, last_ok);
	endtask

	// Oldest legacy-mapped audio and the top generation against version 2
	// limits; slot 1 at generation zero is newer across the wrap.
	task automatic test_extreme_pair();
		draft_record(dsrv_pkg::VERSION_OLD, 32'hffff_ffff, 32'd2, 32'd1, 32'd1);
		emit_draft(1'b0, -1, 1'b1);
		draft_record(dsrv_pkg::VERSION_NEW, 32'h0000_0000, 32'd0, 32'd4, 32'd0);
		emit_draft(1'b1, -1, 1'b1);
	endtask

	// An empty slot 0 whose only word failed to read, then a one-word slot 1.
	task automatic test_failed_source();
		send_item(32'hffff_ffff, 1'b0, 1'b1, 1'b0);
		send_item(32'h0000_0000, 1'b1, 1'b1, 1'b1);
	endtask

	// A correct record followed by an eighth word, which leaves slot 0 invalid.
	task automatic test_overlong_record();
		draft_record(dsrv_pkg::VERSION_NEW, 32'h1234_5678, 32'd1, 32'd2, 32'd0);
		draft[7]  = dsrv_pkg::REC_MAGIC;
		draft_len = 8;
		emit_draft(1'b0, -1, 1'b1);
	endtask

	task automatic test_random_pairs();
		int          shape;
		logic [31:0] g0;
		logic [31:0] g1;
		while (items_sent < PAIR_ITEM_TARGET) begin
			shape = $urandom_range(0, 19);
			g0 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom;
			if (shape == 1)
				random_record(1'b0, $urandom);
			if (shape != 0)
				random_record(1'b0, g0);
			case ($urandom_range(0, 5))
				0: g1 = g0;
				1: g1 = g0 + $urandom_range(1, 50);
				2: g1 = g0 - $urandom_range(1, 50);
				3: g1 = g0 + 32'h8000_0000;
				4: g1 = g0 + 32'h7fff_ffff;
				default: g1 = $urandom;
			endcase
			if (shape != 2)
				random_record(1'b1, g1);
		end
	endtask

	task automatic test_random_noise();
		for (int i = 0; i < NOISE_ITEMS; i++) begin
			send_item($urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 3) != 0);
		end
	endtask

	task automatic flag_mismatch(input string what);
		error_count++;
		$display("tb: mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Report side: checks each transfer and then draws the next ready value.
	always @(posedge clk) begin
		dsrv_pkg::res_item_t want;
		int                  n;
		if (arst_n && res_valid && res_ready) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("report with no record end waiting");
			end else begin
				want = pending_reports.pop_front();
				compare_field("reported_slot", 32'(res_data.reported_slot),
					32'(want.reported_slot));
				compare_field("slot_valid", 32'(res_data.slot_valid), 32'(want.slot_valid));
				compare_field("decision_ready", 32'(res_data.decision_ready),
					32'(want.decision_ready));
				compare_field("chosen_slot", 32'(res_data.chosen_slot),
					32'(want.chosen_slot));
				compare_field("frameskip_out", 32'(res_data.frameskip_out),
					32'(want.frameskip_out));
				compare_field("audio_out", 32'(res_data.audio_out), 32'(want.audio_out));
				compare_field("swap_out", 32'(res_data.swap_out), 32'(want.swap_out));
				compare_field("generation_out", res_data.generation_out, want.generation_out);
				if (want.decision_ready)
					decisions_seen++;
			end
			reports_checked++;
		end
		if (recv_stall > 0) begin
			recv_stall--;
			res_ready <= 1'b0;
		end else begin
			n = idle_len(recv_calm);
			if (n > 0) begin
				recv_stall = n - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		clear_record();
		kept_valid = 1'b0;
		kept_gen   = '0;
		kept_fs    = '0;
		kept_audio = '0;
		kept_swap  = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_pair();
		test_failed_source();
		test_overlong_record();
		test_random_pairs();
		test_random_noise();

		rec_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d words absorbed over %0d record ends, %0d reports checked",
			items_sent, ends_sent, reports_checked);
		$display("tb: %0d slot decisions, %0d mismatches", decisions_seen, error_count);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: timeout with %0d reports outstanding", pending_reports.size());
		$display("tb: failure");
		$finish;
	end

endmodule
